/* sv/rpp_pkg.sv */
// rpp_pkg: shared types and constants of the relativistic particle push unit
// no dependencies; imported by the interfaces, the arithmetic units and the top level
`default_nettype none

package rpp_pkg;

  // default number format, signed q16.16
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned FracBitsDef  = 16;

  // configuration register geometry
  localparam int unsigned DtWidth      = 31;
  localparam int unsigned MassWidth    = 31;
  localparam int unsigned ChargeWidth  = 5;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 31;

  // configuration reset values
  localparam logic [DtWidth-1:0]     DtReset     = 31'd655;
  localparam logic [MassWidth-1:0]   MassReset   = 31'd65536;
  localparam logic [ChargeWidth-1:0] ChargeReset = 5'd1;

  // configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_TIME_STEP       = 2'd0,
    CFG_PARTICLE_MASS   = 2'd1,
    CFG_PARTICLE_CHARGE = 2'd2
  } cfg_idx_e;

  // request codes
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_type_e;

  // status of a multi-cycle unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_G_MUL,
    ST_G_ACC,
    ST_G_START,
    ST_G_ROOT,
    ST_CROSS1,
    ST_CROSS2,
    ST_CROSS3,
    ST_DIV_C,
    ST_QE,
    ST_QE_DIV,
    ST_DIV_F,
    ST_U_GO,
    ST_DIV_U,
    ST_V_GO,
    ST_DIV_V,
    ST_FDT_MUL,
    ST_FDT,
    ST_SUM,
    ST_SMUL,
    ST_POS,
    ST_OUT
  } seq_state_e;

endpackage

`default_nettype wire

/* sv/rpp_if.sv */
// rpp_if: valid/ready channels of the particle push unit (request, response, config)
// depends on rpp_pkg for default widths
`default_nettype none

interface rpp_req_if #(
  parameter int unsigned DATA_WIDTH = rpp_pkg::DataWidthDef
);
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [DATA_WIDTH-1:0] vec_a_x;
  logic signed [DATA_WIDTH-1:0] vec_a_y;
  logic signed [DATA_WIDTH-1:0] vec_a_z;
  logic signed [DATA_WIDTH-1:0] vec_b_x;
  logic signed [DATA_WIDTH-1:0] vec_b_y;
  logic signed [DATA_WIDTH-1:0] vec_b_z;

  modport source (
    output valid, req_type, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z,
    output ready
  );
endinterface

interface rpp_rsp_if #(
  parameter int unsigned DATA_WIDTH = rpp_pkg::DataWidthDef
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] pos_x;
  logic signed [DATA_WIDTH-1:0] pos_y;
  logic signed [DATA_WIDTH-1:0] pos_z;
  logic signed [DATA_WIDTH-1:0] mom_x;
  logic signed [DATA_WIDTH-1:0] mom_y;
  logic signed [DATA_WIDTH-1:0] mom_z;
  logic [DATA_WIDTH-2:0]        lorentz_factor;

  modport source (
    output valid, pos_x, pos_y, pos_z, mom_x, mom_y, mom_z, lorentz_factor,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, mom_x, mom_y, mom_z, lorentz_factor,
    output ready
  );
endinterface

interface rpp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rpp_pkg::CfgIdxWidth-1:0]  index;
  logic [rpp_pkg::CfgDataWidth-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/rpp_mul.sv */
// rpp_mul: shared registered magnitude multiplier with q-format saturating readout
// depends on rpp_pkg for default widths
`default_nettype none

module rpp_mul #(
  parameter int unsigned DATA_WIDTH = rpp_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = rpp_pkg::FracBitsDef,
  parameter int unsigned MUL_WIDTH  = 32
) (
  input  logic                         clk_i,
  input  logic signed [MUL_WIDTH-1:0]  a_i,
  input  logic signed [MUL_WIDTH-1:0]  b_i,
  output logic [2*MUL_WIDTH-1:0]       raw_o,
  output logic signed [DATA_WIDTH-1:0] sat_o
);
  import rpp_pkg::*;

  localparam int unsigned PW = 2 * MUL_WIDTH;
  localparam logic [PW-1:0] MaxMag = PW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic [PW-1:0] TopMag = PW'(64'd1 << (DATA_WIDTH - 1));

  logic [MUL_WIDTH-1:0]  mag_a, mag_b, ua, ub;
  logic [PW-1:0]         prod_q, shifted, lim, capped;
  logic                  neg_q;
  logic [DATA_WIDTH-1:0] res;

  // operand magnitudes
  always_comb begin
    ua    = a_i;
    ub    = b_i;
    mag_a = ua[MUL_WIDTH-1] ? (~ua + 1'b1) : ua;
    mag_b = ub[MUL_WIDTH-1] ? (~ub + 1'b1) : ub;
  end

  // product register
  always_ff @(posedge clk_i) begin
    prod_q <= PW'(mag_a) * PW'(mag_b);
    neg_q  <= a_i[MUL_WIDTH-1] ^ b_i[MUL_WIDTH-1];
  end

  // drop fraction bits, clamp, apply sign
  always_comb begin
    shifted = prod_q >> FRAC_BITS;
    lim     = neg_q ? TopMag : MaxMag;
    capped  = (shifted > lim) ? lim : shifted;
    res     = capped[DATA_WIDTH-1:0];
    sat_o   = neg_q ? -res : res;
  end

  assign raw_o = prod_q;

endmodule

`default_nettype wire

/* sv/rpp_div.sv */
// rpp_div: shared restoring divider, one quotient bit per cycle, saturating result
// depends on rpp_pkg (unit_stat_t)
`default_nettype none

module rpp_div #(
  parameter int unsigned DATA_WIDTH = rpp_pkg::DataWidthDef,
  parameter int unsigned NUM_WIDTH  = 53,
  parameter int unsigned DEN_WIDTH  = 31
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         neg_i,
  input  logic [NUM_WIDTH-1:0]         num_i,
  input  logic [DEN_WIDTH-1:0]         den_i,
  output logic signed [DATA_WIDTH-1:0] quot_o,
  output rpp_pkg::unit_stat_t          stat_o
);
  import rpp_pkg::*;

  localparam int unsigned CntW = $clog2(NUM_WIDTH + 1);
  localparam logic [NUM_WIDTH-1:0] MaxMag =
    NUM_WIDTH'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic [NUM_WIDTH-1:0] TopMag = NUM_WIDTH'(64'd1 << (DATA_WIDTH - 1));

  logic                  busy_q, done_q;
  logic [CntW-1:0]       cnt_q;
  logic [NUM_WIDTH-1:0]  num_q, lim, capped;
  logic [DEN_WIDTH-1:0]  rem_q, den_q;
  logic                  neg_q, zero_q;
  logic signed [DATA_WIDTH-1:0] quot_q;
  logic [DEN_WIDTH:0]    rem_sh, rem_nx;
  logic                  fits, last;
  logic [DATA_WIDTH-1:0] res;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q, num_q[NUM_WIDTH-1]};
    fits   = rem_sh >= {1'b0, den_q};
    rem_nx = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
    last   = cnt_q == CntW'(NUM_WIDTH);
  end

  // saturate quotient magnitude
  always_comb begin
    lim    = neg_q ? TopMag : MaxMag;
    capped = (num_q > lim) ? lim : num_q;
    res    = capped[DATA_WIDTH-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (start_i) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else if (last) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      if (start_i) begin
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        neg_q  <= neg_i;
        zero_q <= num_i == '0;
      end
    end else if (last) begin
      quot_q <= zero_q ? '0 : (neg_q ? -res : res);
    end else begin
      num_q <= {num_q[NUM_WIDTH-2:0], fits};
      rem_q <= rem_nx[DEN_WIDTH-1:0];
    end
  end

  assign quot_o = quot_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

/* sv/rpp_sqrt.sv */
// rpp_sqrt: digit-by-digit integer square root, one root bit per cycle
// depends on rpp_pkg (unit_stat_t)
`default_nettype none

module rpp_sqrt #(
  parameter int unsigned RAD_WIDTH = 66
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [RAD_WIDTH-1:0]       rad_i,
  output logic [RAD_WIDTH/2-1:0]     root_o,
  output rpp_pkg::unit_stat_t        stat_o
);
  import rpp_pkg::*;

  localparam int unsigned RH   = RAD_WIDTH / 2;
  localparam int unsigned CntW = $clog2(RH);

  logic               busy_q, done_q;
  logic [CntW-1:0]    cnt_q;
  logic [RAD_WIDTH-1:0] rad_q;
  logic [RH-1:0]      root_q;
  logic [RH+1:0]      rem_q;
  logic [RH+3:0]      rem_sh, trial, rem_nx;
  logic               fits;

  // trial subtract of the next root bit
  always_comb begin
    rem_sh = {rem_q, rad_q[RAD_WIDTH-1:RAD_WIDTH-2]};
    trial  = {2'b00, root_q, 2'b01};
    fits   = rem_sh >= trial;
    rem_nx = fits ? (rem_sh - trial) : rem_sh;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (start_i) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else if (cnt_q == CntW'(RH - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      if (start_i) begin
        rad_q  <= rad_i;
        root_q <= '0;
        rem_q  <= '0;
      end
    end else begin
      rad_q  <= {rad_q[RAD_WIDTH-3:0], 2'b00};
      root_q <= {root_q[RH-2:0], fits};
      rem_q  <= rem_nx[RH+1:0];
    end
  end

  assign root_o = root_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

/* sv/relativistic_particle_push_unit.sv */
// relativistic_particle_push_unit: top level, sequencer, particle state and config registers
// depends on rpp_pkg, rpp_if, rpp_mul, rpp_div, rpp_sqrt
//
//   channel | dir | handshake        | beat contents
//   cfg_i   | in  | valid/ready      | index, data (register write)
//   req_i   | in  | valid/ready      | req_type, vec_a_x/y/z, vec_b_x/y/z
//   rsp_o   | out | valid/ready      | pos_x/y/z, mom_x/y/z, lorentz_factor
//
// a load beat runs the square root once on the loaded momentum; a step beat runs it
// before and after the push, and the shared divider four times per axis. RW =
// max(DATA_WIDTH,FRAC_BITS)+1 is the square root length and NW = DATA_WIDTH+FRAC_BITS+5
// the divider length; the shared divider makes one quotient bit per cycle.
// one request is in flight at a time; the response sits in an output register, so the
// next request is taken while an unread response waits. reset clears state to zero and
// the config registers to dt 655, mass 1.0, charge 1. config is always ready.
`default_nettype none

module relativistic_particle_push_unit #(
  parameter int unsigned DATA_WIDTH = rpp_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = rpp_pkg::FracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rpp_cfg_if.sink   cfg_i,
  rpp_req_if.sink   req_i,
  rpp_rsp_if.source rsp_o
);
  import rpp_pkg::*;

  localparam int unsigned W     = DATA_WIDTH;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned MulW  = (W > 32) ? W : 32;
  localparam int unsigned DenW  = (W - 1 > MassWidth) ? W - 1 : MassWidth;
  localparam int unsigned NumW  = W + F + ChargeWidth;
  localparam int unsigned RootW = ((W > F) ? W : F) + 1;
  localparam int unsigned RadW  = 2 * RootW;

  localparam logic signed [W-1:0] MaxW = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MinW = {1'b1, {(W-1){1'b0}}};
  localparam logic [RootW-1:0]    GamMax = RootW'({(W-1){1'b1}});
  localparam logic [RadW-1:0]     OneSq = RadW'(1) << (2 * F);

  // saturating add
  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? MinW : MaxW;
    return s[W-1:0];
  endfunction

  // saturating subtract
  function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? MinW : MaxW;
    return s[W-1:0];
  endfunction

  // magnitude of a signed word
  function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
    logic [W-1:0] u;
    u = v;
    return u[W-1] ? (~u + 1'b1) : u;
  endfunction

  // halve, rounding toward zero
  function automatic logic signed [W-1:0] half_tz(input logic signed [W-1:0] v);
    logic [W-1:0] t;
    t = v + {{(W-1){1'b0}}, v[W-1]};
    return {t[W-1], t[W-1:1]};
  endfunction

  seq_state_e state_q, state_d;
  logic [1:0] axis_q, gidx_q, jdx, kdx;
  logic       post_q;

  logic [DtWidth-1:0]            dt_q;
  logic [MassWidth-1:0]          mass_q;
  logic signed [ChargeWidth-1:0] charge_q;

  logic signed [W-1:0] pos_q [3];
  logic signed [W-1:0] mom_q [3];
  logic signed [W-1:0] new_p_q [3];
  logic signed [W-1:0] ea_q [3];
  logic signed [W-1:0] bb_q [3];
  logic signed [W-1:0] m1_q, e_q, f_q, u_q, v_q, fdt_q, s_q;
  logic [RadW-1:0]     acc_q;
  logic [W-2:0]        g_q;

  logic                rsp_valid_q;
  logic signed [W-1:0] rsp_pos_q [3];
  logic signed [W-1:0] rsp_mom_q [3];
  logic [W-2:0]        rsp_gam_q;

  logic signed [MulW-1:0] mul_a, mul_b;
  logic [2*MulW-1:0]      mul_raw;
  logic signed [W-1:0]    mul_sat;

  logic                   div_start, div_neg;
  logic [NumW-1:0]        div_num;
  logic [DenW-1:0]        div_den;
  logic signed [W-1:0]    div_quot;
  unit_stat_t             div_stat;

  logic                   sqrt_start;
  logic [RootW-1:0]       root;
  unit_stat_t             sqrt_stat;

  logic signed [W-1:0]    cross_c;
  logic                   req_acc, rsp_free;

  // shared arithmetic units
  rpp_mul #(.DATA_WIDTH(W), .FRAC_BITS(F), .MUL_WIDTH(MulW)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .raw_o (mul_raw),
    .sat_o (mul_sat)
  );

  rpp_div #(.DATA_WIDTH(W), .NUM_WIDTH(NumW), .DEN_WIDTH(DenW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .neg_i   (div_neg),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  rpp_sqrt #(.RAD_WIDTH(RadW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (acc_q),
    .root_o  (root),
    .stat_o  (sqrt_stat)
  );

  // the two other axes of the cross product
  always_comb begin
    case (axis_q)
      2'd0:    begin jdx = 2'd1; kdx = 2'd2; end
      2'd1:    begin jdx = 2'd2; kdx = 2'd0; end
      default: begin jdx = 2'd0; kdx = 2'd1; end
    endcase
  end

  assign req_i.ready = (state_q == ST_IDLE) && !div_stat.busy && !sqrt_stat.busy;
  assign req_acc     = req_i.valid && req_i.ready;
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  assign cfg_i.ready = 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (req_acc) state_d = ST_G_MUL;
      ST_G_MUL:   state_d = ST_G_ACC;
      ST_G_ACC:   state_d = (gidx_q == 2'd2) ? ST_G_START : ST_G_MUL;
      ST_G_START: state_d = ST_G_ROOT;
      ST_G_ROOT:  if (sqrt_stat.done) state_d = post_q ? ST_OUT : ST_CROSS1;
      ST_CROSS1:  state_d = ST_CROSS2;
      ST_CROSS2:  state_d = ST_CROSS3;
      ST_CROSS3:  state_d = ST_DIV_C;
      ST_DIV_C:   if (div_stat.done) state_d = ST_QE;
      ST_QE:      state_d = ST_QE_DIV;
      ST_QE_DIV:  state_d = ST_DIV_F;
      ST_DIV_F:   if (div_stat.done) state_d = ST_U_GO;
      ST_U_GO:    state_d = ST_DIV_U;
      ST_DIV_U:   if (div_stat.done) state_d = ST_V_GO;
      ST_V_GO:    state_d = ST_DIV_V;
      ST_DIV_V:   if (div_stat.done) state_d = ST_FDT_MUL;
      ST_FDT_MUL: state_d = ST_FDT;
      ST_FDT:     state_d = ST_SUM;
      ST_SUM:     state_d = ST_SMUL;
      ST_SMUL:    state_d = ST_POS;
      ST_POS:     state_d = (axis_q == 2'd2) ? ST_G_MUL : ST_CROSS1;
      ST_OUT:     if (rsp_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // unit operand selection and start strobes
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_neg    = 1'b0;
    div_num    = '0;
    div_den    = DenW'(g_q);
    sqrt_start = 1'b0;
    cross_c    = sat_sub(m1_q, mul_sat);
    case (state_q)
      ST_G_MUL: begin
        mul_a = MulW'(mom_q[gidx_q]);
        mul_b = MulW'(mom_q[gidx_q]);
      end
      ST_G_START: sqrt_start = 1'b1;
      ST_CROSS1: begin
        mul_a = MulW'(mom_q[jdx]);
        mul_b = MulW'(bb_q[kdx]);
      end
      ST_CROSS2: begin
        mul_a = MulW'(mom_q[kdx]);
        mul_b = MulW'(bb_q[jdx]);
      end
      ST_CROSS3: begin
        div_start = 1'b1;
        div_neg   = cross_c[W-1];
        div_num   = NumW'({mag_w(cross_c), {F{1'b0}}});
      end
      ST_QE: begin
        mul_a = MulW'(e_q);
        mul_b = MulW'(charge_q);
      end
      ST_QE_DIV: begin
        div_start = 1'b1;
        div_neg   = e_q[W-1] == charge_q[ChargeWidth-1];
        div_num   = {mul_raw[W+ChargeWidth-1:0], {F{1'b0}}};
        div_den   = DenW'(mass_q);
      end
      ST_U_GO: begin
        div_start = 1'b1;
        div_neg   = mom_q[axis_q][W-1];
        div_num   = NumW'({mag_w(mom_q[axis_q]), {F{1'b0}}});
      end
      ST_V_GO: begin
        div_start = 1'b1;
        div_neg   = u_q[W-1];
        div_num   = NumW'({mag_w(u_q), {F{1'b0}}});
        div_den   = DenW'(mass_q);
      end
      ST_FDT_MUL: begin
        mul_a = MulW'(f_q);
        mul_b = MulW'(dt_q);
      end
      ST_SMUL: begin
        mul_a = MulW'(s_q);
        mul_b = MulW'(dt_q);
      end
      default: ;
    endcase
  end

  // control, config and particle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= '0;
      gidx_q      <= '0;
      post_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
      dt_q        <= DtReset;
      mass_q      <= MassReset;
      charge_q    <= ChargeReset;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        mom_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      // config writes
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_TIME_STEP:       dt_q     <= cfg_i.data[DtWidth-1:0];
          CFG_PARTICLE_MASS:   mass_q   <= cfg_i.data[MassWidth-1:0];
          CFG_PARTICLE_CHARGE: charge_q <= cfg_i.data[ChargeWidth-1:0];
          default: ;
        endcase
      end
      if (rsp_o.ready) rsp_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            gidx_q <= '0;
            axis_q <= '0;
            post_q <= req_i.req_type == REQ_LOAD;
            if (req_i.req_type == REQ_LOAD) begin
              pos_q[0] <= req_i.vec_a_x;
              pos_q[1] <= req_i.vec_a_y;
              pos_q[2] <= req_i.vec_a_z;
              mom_q[0] <= req_i.vec_b_x;
              mom_q[1] <= req_i.vec_b_y;
              mom_q[2] <= req_i.vec_b_z;
            end
          end
        end
        ST_G_ACC: gidx_q <= gidx_q + 1'b1;
        ST_POS: begin
          pos_q[axis_q] <= sat_add(pos_q[axis_q], mul_sat);
          if (axis_q == 2'd2) begin
            for (int i = 0; i < 3; i++) mom_q[i] <= new_p_q[i];
            post_q <= 1'b1;
            gidx_q <= '0;
          end else begin
            axis_q <= axis_q + 1'b1;
          end
        end
        ST_OUT: if (rsp_free) rsp_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // working registers and response payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        ea_q[0] <= req_i.vec_a_x;
        ea_q[1] <= req_i.vec_a_y;
        ea_q[2] <= req_i.vec_a_z;
        bb_q[0] <= req_i.vec_b_x;
        bb_q[1] <= req_i.vec_b_y;
        bb_q[2] <= req_i.vec_b_z;
      end
      ST_G_ACC: begin
        acc_q <= ((gidx_q == 2'd0) ? OneSq : acc_q)
               + RadW'(mul_raw[2*W-1:0]);
      end
      ST_G_ROOT: if (sqrt_stat.done) g_q <= (root > GamMax) ? GamMax[W-2:0] : root[W-2:0];
      ST_CROSS2: m1_q <= mul_sat;
      ST_DIV_C:  if (div_stat.done) e_q <= sat_add(ea_q[axis_q], div_quot);
      ST_DIV_F:  if (div_stat.done) f_q <= div_quot;
      ST_DIV_U:  if (div_stat.done) u_q <= div_quot;
      ST_DIV_V:  if (div_stat.done) v_q <= div_quot;
      ST_FDT: begin
        fdt_q           <= mul_sat;
        new_p_q[axis_q] <= sat_add(mom_q[axis_q], mul_sat);
      end
      ST_SUM: s_q <= sat_add(v_q, half_tz(fdt_q));
      ST_OUT: begin
        if (rsp_free) begin
          for (int i = 0; i < 3; i++) begin
            rsp_pos_q[i] <= pos_q[i];
            rsp_mom_q[i] <= mom_q[i];
          end
          rsp_gam_q <= g_q;
        end
      end
      default: ;
    endcase
  end

  // response beat
  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.pos_x          = rsp_pos_q[0];
  assign rsp_o.pos_y          = rsp_pos_q[1];
  assign rsp_o.pos_z          = rsp_pos_q[2];
  assign rsp_o.mom_x          = rsp_mom_q[0];
  assign rsp_o.mom_y          = rsp_mom_q[1];
  assign rsp_o.mom_z          = rsp_mom_q[2];
  assign rsp_o.lorentz_factor = rsp_gam_q;

endmodule

`default_nettype wire

/* sv/rpp_chk.sv */
// rpp_chk: port-level checks of the particle push unit, bound to the top level
// depends on rpp_pkg for default widths and on relativistic_particle_push_unit
`default_nettype none

module rpp_chk #(
  parameter int unsigned DATA_WIDTH = rpp_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = rpp_pkg::FracBitsDef
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  req_valid_i,
  input logic                  req_ready_i,
  input logic                  rsp_valid_i,
  input logic                  rsp_ready_i,
  input logic [DATA_WIDTH-2:0] lorentz_i
);
  import rpp_pkg::*;

  localparam logic [DATA_WIDTH-2:0] GamOne = (DATA_WIDTH-1)'(1) << FRAC_BITS;

  // a request beat keeps the unit busy on the next cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request taken while a previous one is in flight");

  // no response is produced right after a request beat
  a_no_instant_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !$rose(rsp_valid_i))
    else $error("response appeared one cycle after request");

  // gamma is never below one
  a_gamma_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (lorentz_i >= GamOne))
    else $error("lorentz factor below one");

  // stalled response holds its gamma
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(lorentz_i)))
    else $error("stalled response changed");

endmodule

bind relativistic_particle_push_unit rpp_chk #(
  .DATA_WIDTH(DATA_WIDTH),
  .FRAC_BITS (FRAC_BITS)
) u_rpp_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .lorentz_i   (rsp_o.lorentz_factor)
);

`default_nettype wire

/* sim/relativistic_particle_push_unit_tb.sv */
// relativistic_particle_push_unit_tb: self-checking bench of the particle push unit
// drives load and step beats, predicts every response bit for bit, checks it in order
// depends on rpp_pkg, rpp_if and the relativistic_particle_push_unit top level
`default_nettype none

module relativistic_particle_push_unit_tb;
  import rpp_pkg::*;

  typedef logic signed [31:0] fix_t;
  typedef logic [127:0]       wide_t;

  localparam logic [CfgIdxWidth-1:0] CfgUnused = 2'd3;
  localparam fix_t FixMax = 32'sh7fffffff;
  localparam fix_t FixMin = 32'sh80000000;
  localparam int   IdleLimit = 10000;
  localparam int   HoldCycles = 3000;

  // expected contents of one response beat
  typedef struct {
    fix_t         pos[3];
    fix_t         mom[3];
    logic [30:0]  gamma;
  } particle_rsp_t;

  // ---------------------------------------------------------------------
  // fixed point helpers, signed q16.16 with saturation
  function automatic logic [63:0] mag_of(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic fix_t sat_mag(bit neg, wide_t m);
    wide_t lim;
    logic [31:0] r;
    lim = neg ? wide_t'(64'h8000_0000) : wide_t'(64'h7fff_ffff);
    if (m > lim) m = lim;
    r = m[31:0];
    return neg ? -r : r;
  endfunction

  function automatic fix_t fx_sat64(longint s);
    if (s > longint'(FixMax)) return FixMax;
    if (s < longint'(FixMin)) return FixMin;
    return fix_t'(s);
  endfunction

  function automatic fix_t fx_add(fix_t a, fix_t b);
    return fx_sat64(longint'(a) + longint'(b));
  endfunction

  function automatic fix_t fx_sub(fix_t a, fix_t b);
    return fx_sat64(longint'(a) - longint'(b));
  endfunction

  function automatic fix_t fx_mul(fix_t a, fix_t b);
    wide_t p;
    p = (wide_t'(mag_of(a)) * wide_t'(mag_of(b))) >> 16;
    return sat_mag((a < 0) != (b < 0), p);
  endfunction

  function automatic fix_t fx_div_wide(bit neg, wide_t num, logic [63:0] den);
    if (den == 0) begin
      if (num == 0) return 0;
      return sat_mag(neg, wide_t'(1) << 64);
    end
    return sat_mag(neg, num / wide_t'(den));
  endfunction

  function automatic fix_t fx_div(fix_t a, logic [63:0] den);
    return fx_div_wide(a < 0, wide_t'(mag_of(a)) << 16, den);
  endfunction

  // floor(sqrt(1 + |p|^2)) saturated to the 31 bit range
  function automatic logic [30:0] lorentz_of(fix_t p[3]);
    wide_t s;
    logic [63:0] root, t;
    s = wide_t'(1) << 32;
    for (int i = 0; i < 3; i++) s += wide_t'(mag_of(p[i])) * wide_t'(mag_of(p[i]));
    root = 0;
    for (int i = 63; i >= 0; i--) begin
      t = root | (64'd1 << i);
      if (wide_t'(t) * wide_t'(t) <= s) root = t;
    end
    return root > 64'h7fff_ffff ? 31'h7fff_ffff : root[30:0];
  endfunction

  // ---------------------------------------------------------------------
  // scoreboard: particle model plus queue of expected responses
  class push_scoreboard;
    fix_t               pos[3];
    fix_t               mom[3];
    logic [30:0]        dt;
    logic [30:0]        mass;
    logic signed [4:0]  charge;
    particle_rsp_t      expected_rsps[$];
    int                 errors;

    function new();
      foreach (pos[i]) begin
        pos[i] = 0;
        mom[i] = 0;
      end
      dt = DtReset;
      mass = MassReset;
      charge = ChargeReset;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [30:0] val);
      case (idx)
        CFG_TIME_STEP:       dt = val;
        CFG_PARTICLE_MASS:   mass = val;
        CFG_PARTICLE_CHARGE: charge = val[4:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_rsps.size();
    endfunction

    // advance the model by one accepted request beat
    function void note_request(req_type_e kind, fix_t a[3], fix_t b[3]);
      fix_t nr[3], np[3];
      fix_t c, e, f, v, fdt, h, dtf;
      logic [63:0] g;
      wide_t qe;
      int j, k;
      particle_rsp_t r;
      if (kind == REQ_LOAD) begin
        nr = a;
        np = b;
      end else begin
        g = 64'(lorentz_of(mom));
        dtf = fix_t'({1'b0, dt});
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          c = fx_sub(fx_mul(mom[j], b[k]), fx_mul(mom[k], b[j]));
          e = fx_add(a[i], fx_div(c, g));
          qe = (wide_t'(mag_of(e)) * wide_t'(mag_of(longint'(charge)))) << 16;
          f = fx_div_wide(!((e < 0) != (charge < 0)), qe, 64'(mass));
          v = fx_div(fx_div(mom[i], g), 64'(mass));
          fdt = fx_mul(f, dtf);
          h = fdt / 2;
          nr[i] = fx_add(pos[i], fx_mul(fx_add(v, h), dtf));
          np[i] = fx_add(mom[i], fdt);
        end
      end
      pos = nr;
      mom = np;
      r.pos = pos;
      r.mom = mom;
      r.gamma = lorentz_of(mom);
      expected_rsps.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_response(fix_t px, fix_t py, fix_t pz,
                                 fix_t mx, fix_t my, fix_t mz, logic [30:0] gm);
      particle_rsp_t r;
      if (expected_rsps.size() == 0) begin
        $error("response beat with no request outstanding");
        errors++;
        return;
      end
      r = expected_rsps.pop_front();
      compare_field("pos_x", r.pos[0], px);
      compare_field("pos_y", r.pos[1], py);
      compare_field("pos_z", r.pos[2], pz);
      compare_field("mom_x", r.mom[0], mx);
      compare_field("mom_y", r.mom[1], my);
      compare_field("mom_z", r.mom[2], mz);
      compare_field("lorentz_factor", {1'b0, r.gamma}, {1'b0, gm});
    endfunction
  endclass

  // ---------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni;

  rpp_cfg_if cfg ();
  rpp_req_if req ();
  rpp_rsp_if rsp ();

  relativistic_particle_push_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  push_scoreboard sb = new();

  always #6 clk_i = ~clk_i;

  int  burst_left = 0;
  bit  hold_go = 1'b0;
  int  idle_cycles = 0;

  // response side: stall pattern, long hold on request, checking
  initial begin
    int mode, left, hold;
    mode = 0;
    left = 0;
    hold = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp.valid && rsp.ready)
        sb.check_response(rsp.pos_x, rsp.pos_y, rsp.pos_z,
                          rsp.mom_x, rsp.mom_y, rsp.mom_z, rsp.lorentz_factor);
      if (hold_go) begin
        hold_go = 1'b0;
        hold = HoldCycles;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(50, 400);
      end
      left--;
      if (hold > 0) begin
        hold--;
        rsp.ready <= 1'b0;
      end else begin
        case (mode)
          0:       rsp.ready <= 1'b1;
          1:       rsp.ready <= $urandom_range(0, 1);
          default: rsp.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // drivers
  task automatic write_cfg(logic [CfgIdxWidth-1:0] idx, logic [30:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    sb.write_reg(idx, val);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // one request beat, followed by burst bookkeeping and a possible gap
  task automatic send_req(req_type_e kind, fix_t a[3], fix_t b[3]);
    req.valid    <= 1'b1;
    req.req_type <= kind;
    req.vec_a_x  <= a[0];
    req.vec_a_y  <= a[1];
    req.vec_a_z  <= a[2];
    req.vec_b_x  <= b[0];
    req.vec_b_y  <= b[1];
    req.vec_b_z  <= b[2];
    do @(posedge clk_i); while (!req.ready);
    sb.note_request(kind, a, b);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 6);
    end
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // random field value: mostly physical magnitudes, some full range and extremes
  function automatic fix_t pick_val(int scale);
    case ($urandom_range(0, 9))
      0, 1:    return fix_t'($urandom);
      2:       return fix_t'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      3: begin
        case ($urandom_range(0, 4))
          0:       return FixMax;
          1:       return FixMin;
          2:       return 0;
          3:       return -1;
          default: return 1;
        endcase
      end
      default: return fix_t'($urandom_range(0, 2 * scale)) - scale;
    endcase
  endfunction

  task automatic send_vecs(req_type_e kind, fix_t ax, fix_t ay, fix_t az,
                           fix_t bx, fix_t by, fix_t bz);
    fix_t a[3], b[3];
    a = '{ax, ay, az};
    b = '{bx, by, bz};
    send_req(kind, a, b);
  endtask

  task automatic random_phase(int count);
    fix_t a[3], b[3];
    int sent, steps;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 7) == 0) begin
        // noise: lone beat with arbitrary content
        foreach (a[i]) begin
          a[i] = fix_t'($urandom);
          b[i] = fix_t'($urandom);
        end
        send_req($urandom_range(0, 1) ? REQ_STEP : REQ_LOAD, a, b);
        sent++;
      end else begin
        foreach (a[i]) begin
          a[i] = pick_val(32'h0010_0000);
          b[i] = pick_val(32'h0004_0000);
        end
        send_req(REQ_LOAD, a, b);
        sent++;
        steps = $urandom_range(2, 8);
        repeat (steps) begin
          foreach (a[i]) begin
            a[i] = pick_val(32'h0008_0000);
            b[i] = pick_val(32'h0004_0000);
          end
          send_req(REQ_STEP, a, b);
          sent++;
        end
      end
    end
  endtask

  task automatic set_params(logic [30:0] dt, logic [30:0] mass, logic [30:0] charge);
    write_cfg(CFG_TIME_STEP, dt);
    write_cfg(CFG_PARTICLE_MASS, mass);
    write_cfg(CFG_PARTICLE_CHARGE, charge);
  endtask

  // ---------------------------------------------------------------------
  initial begin
    rst_ni       <= 1'b0;
    cfg.valid    <= 1'b0;
    cfg.index    <= CFG_TIME_STEP;
    cfg.data     <= '0;
    req.valid    <= 1'b0;
    req.req_type <= REQ_LOAD;
    req.vec_a_x  <= '0;
    req.vec_a_y  <= '0;
    req.vec_a_z  <= '0;
    req.vec_b_x  <= '0;
    req.vec_b_y  <= '0;
    req.vec_b_z  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset state, extremes of every field, gamma overflow
    send_vecs(REQ_STEP, 0, 0, 0, 0, 0, 0);
    send_vecs(REQ_LOAD, FixMax, FixMin, 0, FixMax, FixMin, FixMax);
    send_vecs(REQ_STEP, FixMax, FixMin, -1, FixMin, FixMax, 1);
    send_vecs(REQ_LOAD, FixMin, FixMax, -1, FixMin, FixMin, FixMin);
    send_vecs(REQ_STEP, FixMin, FixMax, FixMax, FixMax, FixMax, FixMin);
    send_vecs(REQ_LOAD, 32'sh0001_0000, -32'sh0002_0000, 0,
              32'sh0000_8000, 32'sh0001_0000, -32'sh0000_4000);
    send_vecs(REQ_STEP, 32'sh0001_0000, 0, -32'sh0001_0000,
              0, 0, 32'sh0002_0000);
    send_vecs(REQ_STEP, -1, 1, 0, 1, -1, 0);
    drain();

    // extremes: largest step, smallest mass, largest charge; unused index
    set_params(31'h7fff_ffff, 31'd1, 31'd15);
    write_cfg(CfgUnused, 31'h7fff_ffff);
    send_vecs(REQ_LOAD, 32'sh0010_0000, 0, 0, 32'sh0001_0000, -32'sh0001_0000, 0);
    send_vecs(REQ_STEP, 32'sh0001_0000, FixMin, FixMax, 32'sh0001_0000, 0, FixMin);
    send_vecs(REQ_STEP, 0, 0, 0, 0, 0, 0);
    drain();

    // zero mass and zero step, smallest charge
    set_params(31'd0, 31'd0, 31'h10);
    send_vecs(REQ_LOAD, 32'sh0003_0000, 0, 0, 32'sh0001_0000, 0, 0);
    send_vecs(REQ_STEP, 32'sh0001_0000, -32'sh0001_0000, 0, 0, 0, 32'sh0001_0000);
    drain();
    write_cfg(CFG_TIME_STEP, 31'd655);
    send_vecs(REQ_STEP, 0, 0, 0, 0, 0, 0);
    send_vecs(REQ_LOAD, 0, 0, 0, 0, 0, 0);
    send_vecs(REQ_STEP, 0, 0, 0, 0, 0, 0);
    drain();

    // random phases over several settings, defaults first
    set_params(DtReset, MassReset, 31'(ChargeReset));
    random_phase(125);
    hold_go = 1'b1;
    random_phase(125);
    drain();
    set_params(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffef);
    random_phase(100);
    drain();
    set_params(31'd0, 31'd1, 31'd0);
    random_phase(100);
    drain();
    set_params(31'd65536, 31'd0, 31'h1f);
    random_phase(100);
    drain();
    set_params(31'($urandom_range(0, 32'h0002_0000)), 31'($urandom), 31'($urandom));
    random_phase(100);
    drain();
    set_params(31'($urandom), 31'($urandom_range(1, 32'h0010_0000)), 31'($urandom));
    random_phase(100);

    drain();
    repeat (1000) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* relativistic_particle_push_unit.f */
sv/rpp_pkg.sv
sv/rpp_if.sv
sv/rpp_mul.sv
sv/rpp_div.sv
sv/rpp_sqrt.sv
sv/relativistic_particle_push_unit.sv
sv/rpp_chk.sv
sim/relativistic_particle_push_unit_tb.sv
